[design/mahd_pkg.sv]
`default_nettype none

package mahd_pkg;

  // Field widths of one header beat and one result beat.
  localparam int unsigned HDR_W   = 32;
  localparam int unsigned LEN_W   = 12;
  localparam int unsigned LAYER_W = 2;
  localparam int unsigned VER_W   = 2;
  localparam int unsigned CHAN_W  = 2;
  localparam int unsigned KBPS_W  = 9;
  localparam int unsigned RATE_W  = 16;
  localparam int unsigned COEF_W  = 18;
  localparam int unsigned IDX_W   = 2;

  // Frame length arithmetic: numerator = coefficient * kbps, then a reciprocal
  // multiply by one of the three base sampling rates, then a power-of-two shift.
  localparam int unsigned NUM_W   = 26;
  localparam int unsigned RECIP_W = 28;
  localparam int unsigned PROD_W  = NUM_W + RECIP_W;
  localparam int unsigned RECIP_S = 40;
  localparam int unsigned QUOT_W  = PROD_W - RECIP_S;

  localparam logic [HDR_W-1:0] SYNC_MASK = 32'hFFE0_0000;

  localparam logic [COEF_W-1:0] COEF_L1   = 18'd12000;
  localparam logic [COEF_W-1:0] COEF_HALF = 18'd72000;
  localparam logic [COEF_W-1:0] COEF_FULL = 18'd144000;

  // Version codes as carried in the result.
  localparam logic [VER_W-1:0] VER_MPEG1  = 2'd0;
  localparam logic [VER_W-1:0] VER_MPEG2  = 2'd1;
  localparam logic [VER_W-1:0] VER_MPEG25 = 2'd2;

  // Version codes as they appear in the header.
  localparam logic [1:0] HVER_MPEG1    = 2'b11;
  localparam logic [1:0] HVER_MPEG2    = 2'b10;
  localparam logic [1:0] HVER_RESERVED = 2'b01;

  localparam logic [1:0] HLAYER_RESERVED = 2'b00;
  localparam logic [1:0] SR_RESERVED     = 2'b11;
  localparam logic [3:0] BR_FREE         = 4'd0;
  localparam logic [3:0] BR_BAD          = 4'd15;
  localparam logic [1:0] MODE_MONO       = 2'b11;

  localparam logic [LAYER_W-1:0] LAYER_I   = 2'd1;
  localparam logic [LAYER_W-1:0] LAYER_III = 2'd3;

  // MPEG-2.5 sampling rates; MPEG-2 doubles them and MPEG-1 quadruples them.
  localparam logic [RATE_W-1:0] BASE_RATE [3] = '{16'd11025, 16'd12000, 16'd8000};

  // ceil(2^40 / base rate); exact floor division for any numerator below 2^26.
  localparam logic [RECIP_W-1:0] RECIP [3] = '{28'd99728946, 28'd91625969, 28'd137438954};

  // [0 MPEG-1, 1 MPEG-2 and 2.5][layer - 1][bitrate index]
  localparam logic [KBPS_W-1:0] KBPS_TAB [2][3][16] = '{
    '{
      '{9'd0, 9'd32, 9'd64, 9'd96, 9'd128, 9'd160, 9'd192, 9'd224,
        9'd256, 9'd288, 9'd320, 9'd352, 9'd384, 9'd416, 9'd448, 9'd0},
      '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
        9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd384, 9'd0},
      '{9'd0, 9'd32, 9'd40, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96,
        9'd112, 9'd128, 9'd160, 9'd192, 9'd224, 9'd256, 9'd320, 9'd0}
    },
    '{
      '{9'd0, 9'd32, 9'd48, 9'd56, 9'd64, 9'd80, 9'd96, 9'd112,
        9'd128, 9'd144, 9'd160, 9'd176, 9'd192, 9'd224, 9'd256, 9'd0},
      '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
        9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0},
      '{9'd0, 9'd8, 9'd16, 9'd24, 9'd32, 9'd40, 9'd48, 9'd56,
        9'd64, 9'd80, 9'd96, 9'd112, 9'd128, 9'd144, 9'd160, 9'd0}
    }
  };

  // A classified header waiting for its frame length.
  typedef struct packed {
    logic                 valid_res;
    logic [LAYER_W-1:0]   layer;
    logic [VER_W-1:0]     mpeg_version;
    logic [CHAN_W-1:0]    channels;
    logic [KBPS_W-1:0]    bitrate_kbps;
    logic [RATE_W-1:0]    sample_rate_hz;
    logic [COEF_W-1:0]    coef;
    logic [IDX_W-1:0]     sr_idx;
    logic                 pad;
  } item_t;

  // One finished result.
  typedef struct packed {
    logic                 valid_res;
    logic [LEN_W-1:0]     frame_bytes;
    logic [LAYER_W-1:0]   layer;
    logic [VER_W-1:0]     mpeg_version;
    logic [CHAN_W-1:0]    channels;
    logic [KBPS_W-1:0]    bitrate_kbps;
    logic [RATE_W-1:0]    sample_rate_hz;
  } result_t;

endpackage

`default_nettype wire

[design/mahd_front.sv]
`default_nettype none

module mahd_front
  import mahd_pkg::*;
(
  input  wire logic             in_valid_i,
  output logic                  in_ready_o,
  input  wire logic [HDR_W-1:0] header_i,
  input  wire logic             queue_full_i,
  output logic                  push_o,
  output item_t                 item_o
);

  logic [1:0]         sr;
  logic [3:0]         br;
  logic [1:0]         lay_code;
  logic [1:0]         ver_code;
  logic               legal;
  logic [LAYER_W-1:0] lay;
  logic [VER_W-1:0]   ver;
  logic               row;
  logic [1:0]         rate_shift;
  logic [COEF_W-1:0]  coef;

  assign sr       = header_i[11:10];
  assign br       = header_i[15:12];
  assign lay_code = header_i[18:17];
  assign ver_code = header_i[20:19];

  assign legal = ((header_i & SYNC_MASK) == SYNC_MASK) && (sr != SR_RESERVED) &&
                 (br != BR_FREE) && (br != BR_BAD) &&
                 (lay_code != HLAYER_RESERVED) && (ver_code != HVER_RESERVED);

  // Layer code 11 is Layer I, 10 Layer II, 01 Layer III.
  assign lay = LAYER_W'(3'd4 - {1'b0, lay_code});

  always_comb begin
    case (ver_code)
      HVER_MPEG1: ver = VER_MPEG1;
      HVER_MPEG2: ver = VER_MPEG2;
      default:    ver = VER_MPEG25;
    endcase
  end

  assign row        = (ver != VER_MPEG1);
  assign rate_shift = 2'(VER_MPEG25 - ver);

  always_comb begin
    if (lay == LAYER_I) begin
      coef = COEF_L1;
    end else if (lay == LAYER_III && ver != VER_MPEG1) begin
      coef = COEF_HALF;
    end else begin
      coef = COEF_FULL;
    end
  end

  always_comb begin
    item_o = '0;
    if (legal) begin
      item_o.valid_res      = 1'b1;
      item_o.layer          = lay;
      item_o.mpeg_version   = ver;
      item_o.channels       = (header_i[7:6] == MODE_MONO) ? 2'd1 : 2'd2;
      item_o.bitrate_kbps   = KBPS_TAB[row][lay - 2'd1][br];
      item_o.sample_rate_hz = BASE_RATE[sr] << rate_shift;
      item_o.coef           = coef;
      item_o.sr_idx         = sr;
      item_o.pad            = header_i[9];
    end
  end

  assign in_ready_o = !queue_full_i;
  assign push_o     = in_valid_i && !queue_full_i;

endmodule

`default_nettype wire

[design/mahd_queue.sv]
`default_nettype none

module mahd_queue
  import mahd_pkg::*;
#(
  parameter int unsigned DEPTH = 2
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire item_t item_i,
  output logic       full_o,
  output logic       rd_valid_o,
  input  wire logic  rd_ready_i,
  output item_t      item_o
);

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  item_t            mem_q [DEPTH];
  logic [PTR_W-1:0] wr_ptr_q, wr_ptr_d;
  logic [PTR_W-1:0] rd_ptr_q, rd_ptr_d;
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             pop;

  assign full_o     = (cnt_q == FULL_CNT);
  assign rd_valid_o = (cnt_q != '0);
  assign pop        = rd_valid_o && rd_ready_i;
  assign item_o     = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

endmodule

`default_nettype wire

[design/mahd_back.sv]
`default_nettype none

module mahd_back
  import mahd_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  input  wire item_t item_i,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output result_t    result_o
);

  logic              s1_v_q, s2_v_q, s3_v_q;
  logic              s1_ready, s2_ready, s3_ready;
  item_t             s1_item_q, s2_item_q;
  logic [NUM_W-1:0]  s1_num_q;
  logic [QUOT_W-1:0] s2_quot_q;
  result_t           s3_res_q;

  logic [COEF_W+KBPS_W-1:0] num_full;
  logic [PROD_W-1:0]        prod;
  logic [1:0]               shamt;
  logic [QUOT_W-1:0]        shifted;
  logic [LEN_W-1:0]         base_len;
  logic [LEN_W-1:0]         len;

  // A stage moves when it is empty or the stage after it moves.
  assign s3_ready   = !s3_v_q || out_ready_i;
  assign s2_ready   = !s2_v_q || s3_ready;
  assign s1_ready   = !s1_v_q || s2_ready;
  assign in_ready_o = s1_ready;

  // Numerator stays below 2^26 for every legal table combination.
  assign num_full = (COEF_W + KBPS_W)'(item_i.coef) * (COEF_W + KBPS_W)'(item_i.bitrate_kbps);

  assign prod = PROD_W'(s1_num_q) * PROD_W'(RECIP[s1_item_q.sr_idx]);

  assign shamt    = 2'(VER_MPEG25 - s2_item_q.mpeg_version);
  assign shifted  = s2_quot_q >> shamt;
  assign base_len = LEN_W'(shifted) + LEN_W'(s2_item_q.pad);
  assign len      = (s2_item_q.layer == LAYER_I) ? (base_len << 2) : base_len;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
      s3_v_q <= 1'b0;
    end else begin
      if (s1_ready) begin
        s1_v_q <= in_valid_i;
      end
      if (s2_ready) begin
        s2_v_q <= s1_v_q;
      end
      if (s3_ready) begin
        s3_v_q <= s2_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_ready && in_valid_i) begin
      s1_item_q <= item_i;
      s1_num_q  <= NUM_W'(num_full);
    end
    if (s2_ready && s1_v_q) begin
      s2_item_q <= s1_item_q;
      s2_quot_q <= prod[PROD_W-1:RECIP_S];
    end
    if (s3_ready && s2_v_q) begin
      s3_res_q.valid_res      <= s2_item_q.valid_res;
      s3_res_q.frame_bytes    <= len;
      s3_res_q.layer          <= s2_item_q.layer;
      s3_res_q.mpeg_version   <= s2_item_q.mpeg_version;
      s3_res_q.channels       <= s2_item_q.channels;
      s3_res_q.bitrate_kbps   <= s2_item_q.bitrate_kbps;
      s3_res_q.sample_rate_hz <= s2_item_q.sample_rate_hz;
    end
  end

  assign out_valid_o = s3_v_q;
  assign result_o    = s3_res_q;

endmodule

`default_nettype wire

[design/mpeg_audio_header_decoder.sv]
// MPEG audio frame header decoder.
// The slave stream takes one 32-bit frame header per beat, first header byte in
// bits 31..24. The master stream returns exactly one result beat per header, in
// order. tuser carries the legal-header flag; tdata carries frame length, layer,
// version, channel count, bitrate and sampling rate. A rejected header gives a
// result with the flag low and every other field zero.
// A front stage checks the sync and reserved codes and does the table lookups,
// then writes the classified header into a small queue. The back end is a
// three-stage pipeline: coefficient times bitrate, a reciprocal multiply for
// the sampling rate division, then shift, padding and the Layer I slot scaling
// into the output register.
// Throughput is one header per cycle while the master side keeps tready high. An
// accepted header passes the queue, numerator, quotient and output registers.
// When the receiver holds tready low, the pipeline fills and then the queue,
// and tready on the slave side drops only once the queue is full.
// Reset clears the queue and all stage valid flags; no results are pending.
`default_nettype none

module mpeg_audio_header_decoder
  import mahd_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 2
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [31:0] s_axis_tdata,   // [31:0] header_word
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [47:0]      m_axis_tdata,   // [11:0] frame_bytes, [13:12] layer,
                                           // [15:14] mpeg_version, [17:16] channels,
                                           // [26:18] bitrate_kbps,
                                           // [42:27] sample_rate_hz, [47:43] zero
  output logic [0:0]       m_axis_tuser    // [0] valid_res
);

  item_t   front_item;
  item_t   queue_item;
  logic    push;
  logic    queue_full;
  logic    queue_valid;
  logic    back_ready;
  result_t result;

  mahd_front u_front (
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .header_i     (s_axis_tdata),
    .queue_full_i (queue_full),
    .push_o       (push),
    .item_o       (front_item)
  );

  mahd_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push),
    .item_i     (front_item),
    .full_o     (queue_full),
    .rd_valid_o (queue_valid),
    .rd_ready_i (back_ready),
    .item_o     (queue_item)
  );

  mahd_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (queue_valid),
    .in_ready_o  (back_ready),
    .item_i      (queue_item),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .result_o    (result)
  );

  assign m_axis_tdata = {5'b0, result.sample_rate_hz, result.bitrate_kbps, result.channels,
                         result.mpeg_version, result.layer, result.frame_bytes};
  assign m_axis_tuser = result.valid_res;

endmodule

`default_nettype wire
